[rtl/core/ttdg_pkg.sv]
// ----------------------------------------------------------------------------
// ttdg_pkg
// Types, codes and helpers shared by the tap and drag gesture engine.
// ----------------------------------------------------------------------------
package ttdg_pkg;

  // Timer width: a countdown holds the armed value plus one.
  localparam int unsigned TimerBits = 10;
  localparam int unsigned TimerCntW = TimerBits + 1;
  localparam logic [9:0]  TickMask  = 10'((1 << TimerBits) - 1);

  // Transaction kinds
  localparam logic [1:0] ReqPen  = 2'd0;
  localparam logic [1:0] ReqTick = 2'd1;
  localparam logic [1:0] ReqRead = 2'd2;

  // Packet formats
  localparam logic [1:0] ModeRaw    = 2'd0;
  localparam logic [1:0] ModeDebug  = 2'd1;
  localparam logic [1:0] ModePs2    = 2'd2;
  localparam logic [1:0] ModeUnused = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] RegReportMode = 2'd0;
  localparam logic [1:0] RegBounce     = 2'd1;
  localparam logic [1:0] RegSticky     = 2'd2;
  localparam logic [1:0] RegTapWindow  = 2'd3;

  // Debounce phase codes
  localparam logic [1:0] PhaseNone   = 2'd0;
  localparam logic [1:0] PhaseUp     = 2'd1;
  localparam logic [1:0] PhaseDown   = 2'd2;
  localparam logic [1:0] PhaseSticky = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [9:0] x_coord;
    logic [9:0] y_coord;
    logic       pen_down;
  } ttdg_in_t;

  typedef struct packed {
    logic       packet_valid;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic       data_ready;
  } ttdg_out_t;

  // Load value for a countdown armed with the given tick count.
  function automatic logic [TimerCntW-1:0] arm_timer(input logic [9:0] ticks);
    arm_timer = TimerCntW'(ticks & TickMask) + TimerCntW'(1);
  endfunction

endpackage

[rtl/core/touchpad_tap_drag_gesture_engine.sv]
// ----------------------------------------------------------------------------
// touchpad_tap_drag_gesture_engine
// Debounces pen contact, turns tap gestures into button pulses and answers
// host reads with raw, debug or relative PS/2 packets.
// An accepted transaction passes the input register, then the result register.
// Throughput: 1 transaction per cycle while results are taken; all work for
// an item is one pass of logic between the input register and the result register.
// Reset: rst_ni clears all gesture state and loads the register defaults
// (relative PS/2 mode, bounce 5, sticky drag 80, tap window 30 ticks).
// ----------------------------------------------------------------------------
module touchpad_tap_drag_gesture_engine
  import ttdg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ttdg_in_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ttdg_out_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [9:0] cfg_data_i
);

  // Configuration registers
  logic [1:0] report_mode_q;
  logic [9:0] bounce_ticks_q, sticky_ticks_q, tap_window_q;

  // Input and result registers
  logic      in_valid_q, out_valid_q;
  ttdg_in_t  in_data_q;
  ttdg_out_t out_data_q, out_data_d;
  logic      advance;

  // Gesture state
  logic [9:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [9:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic       contact_raw_q, contact_raw_d;
  logic       contact_filt_q, contact_filt_d;
  logic       stroke_q, stroke_d;
  logic [1:0] phase_q, phase_d;
  logic [TimerCntW-1:0] bounce_cd_q, bounce_cd_d, tap_cd_q, tap_cd_d;
  logic       gesture_open_q, gesture_open_d;
  logic [3:0] edge_count_q, edge_count_d;
  logic [3:0] pulses_q, pulses_d;
  logic       button_chg_q, button_chg_d;
  logic       move_chg_q, move_chg_d;

  // Per-item helpers
  logic        do_trans;
  logic        bounce_fire, tap_fire;
  logic [4:0]  pulse_sum;
  logic [3:0]  pulses_dec, pulses_after;
  logic        button_bit;
  logic        move_ok;
  logic [10:0] dx_raw, dy_raw, dx, dy;

  // The result register frees itself when its transaction is taken, so the
  // input side keeps moving as long as results are taken.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Configuration writes land at once; the host writes only while idle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_mode_q  <= ModePs2;
      bounce_ticks_q <= 10'd5;
      sticky_ticks_q <= 10'd80;
      tap_window_q   <= 10'd30;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegReportMode: report_mode_q  <= cfg_data_i[1:0];
        RegBounce:     bounce_ticks_q <= cfg_data_i;
        RegSticky:     sticky_ticks_q <= cfg_data_i;
        RegTapWindow:  tap_window_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A countdown fires on the tick where it reaches one: counts of one and
  // two both fire on this tick.
  assign bounce_fire = (bounce_cd_q == TimerCntW'(1)) || (bounce_cd_q == TimerCntW'(2));
  assign tap_fire    = (tap_cd_q == TimerCntW'(1)) || (tap_cd_q == TimerCntW'(2));

  // Tap expiry adds the edge count to the owed pulses, saturating at 15.
  assign pulse_sum = {1'b0, pulses_q} + {1'b0, edge_count_q};

  // Button read: consume one owed half-pulse, else report a held drag.
  assign pulses_dec   = pulses_q - 4'd1;
  assign pulses_after = (pulses_q != 4'd0) ? pulses_dec : pulses_q;
  assign button_bit   = (pulses_q != 4'd0) ? pulses_dec[0]
                                           : (!gesture_open_q && edge_count_q == 4'd3);

  // Relative motion since the last PS/2 read; zero across a stroke start or
  // while a debounce is pending.
  assign move_ok = !stroke_q && (phase_q == PhaseNone);
  assign dx_raw  = {1'b0, pos_x_q} - {1'b0, prev_x_q};
  assign dy_raw  = {1'b0, prev_y_q} - {1'b0, pos_y_q};
  assign dx      = move_ok ? dx_raw : 11'd0;
  assign dy      = move_ok ? dy_raw : 11'd0;

  always_comb begin
    pos_x_d        = pos_x_q;
    pos_y_d        = pos_y_q;
    prev_x_d       = prev_x_q;
    prev_y_d       = prev_y_q;
    contact_raw_d  = contact_raw_q;
    contact_filt_d = contact_filt_q;
    stroke_d       = stroke_q;
    phase_d        = phase_q;
    bounce_cd_d    = bounce_cd_q;
    tap_cd_d       = tap_cd_q;
    gesture_open_d = gesture_open_q;
    edge_count_d   = edge_count_q;
    pulses_d       = pulses_q;
    button_chg_d   = button_chg_q;
    move_chg_d     = move_chg_q;
    do_trans       = 1'b0;
    out_data_d     = '0;

    unique case (in_data_q.req_type)
      ReqPen: begin
        if (in_data_q.x_coord != pos_x_q || in_data_q.y_coord != pos_y_q) begin
          pos_x_d    = in_data_q.x_coord;
          pos_y_d    = in_data_q.y_coord;
          move_chg_d = 1'b1;
        end
        if (in_data_q.pen_down != contact_raw_q) begin
          contact_raw_d = in_data_q.pen_down;
          // Any contact change cancels a pending debounce.
          if (phase_q != PhaseNone) begin
            phase_d     = PhaseNone;
            bounce_cd_d = '0;
          end
          if (in_data_q.pen_down) begin
            if (contact_filt_q) begin
              stroke_d = 1'b1;
            end else begin
              // Pen-down is taken at once, then guarded against bounce.
              phase_d        = PhaseDown;
              bounce_cd_d    = arm_timer(bounce_ticks_q);
              contact_filt_d = 1'b1;
              do_trans       = 1'b1;
            end
          end else if (gesture_open_q) begin
            contact_filt_d = 1'b0;
            do_trans       = 1'b1;
          end else if (edge_count_q == 4'd3) begin
            // Tap-and-drag: hold the lift for the longer sticky time.
            phase_d     = PhaseSticky;
            bounce_cd_d = arm_timer(sticky_ticks_q);
          end else begin
            phase_d     = PhaseUp;
            bounce_cd_d = arm_timer(bounce_ticks_q);
          end
        end
      end
      ReqTick: begin
        if (bounce_fire) begin
          bounce_cd_d = '0;
        end else if (bounce_cd_q != '0) begin
          bounce_cd_d = bounce_cd_q - TimerCntW'(1);
        end
        if (tap_fire) begin
          tap_cd_d = '0;
        end else if (tap_cd_q != '0) begin
          tap_cd_d = tap_cd_q - TimerCntW'(1);
        end
        // Bounce expiry goes first.
        if (bounce_fire) begin
          if (phase_q == PhaseUp || phase_q == PhaseSticky) begin
            phase_d        = PhaseNone;
            contact_filt_d = contact_raw_q;
            do_trans       = 1'b1;
          end else if (phase_q == PhaseDown) begin
            phase_d = PhaseNone;
          end
        end
        // Drop the tap expiry when the bounce expiry re-armed the window.
        if (tap_fire && !do_trans) begin
          if (edge_count_q == 4'd2 || edge_count_q == 4'd4 || edge_count_q == 4'd6) begin
            pulses_d     = (pulse_sum > 5'd15) ? 4'd15 : pulse_sum[3:0];
            button_chg_d = 1'b1;
          end
          gesture_open_d = 1'b0;
        end
      end
      ReqRead: begin
        if (report_mode_q != ModeUnused) begin
          move_chg_d              = 1'b0;
          stroke_d                = 1'b0;
          out_data_d.packet_valid = 1'b1;
          unique case (report_mode_q)
            ModeRaw: begin
              out_data_d.byte0 = {contact_raw_q, 1'b0, pos_x_q[9:8],
                                  contact_filt_q, 1'b0, pos_y_q[9:8]};
              out_data_d.byte1 = pos_x_q[7:0];
              out_data_d.byte2 = pos_y_q[7:0];
            end
            ModeDebug: begin
              out_data_d.byte0 = {contact_raw_q, contact_filt_q, stroke_q, 3'b000, phase_q};
              out_data_d.byte1 = {gesture_open_q, 3'b000, edge_count_q};
              out_data_d.byte2 = {pulses_after, 3'b000, button_bit};
              pulses_d         = pulses_after;
              button_chg_d     = (pulses_after != 4'd0);
            end
            ModePs2: begin
              out_data_d.byte0 = {2'b00, dy[10], dx[10], !button_bit, 3'b000};
              out_data_d.byte1 = dx[7:0];
              out_data_d.byte2 = dy[7:0];
              pulses_d         = pulses_after;
              button_chg_d     = (pulses_after != 4'd0);
              prev_x_d         = pos_x_q;
              prev_y_d         = pos_y_q;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    // Record an accepted transition: open or extend the gesture.
    if (do_trans) begin
      if (gesture_open_q) begin
        edge_count_d = (edge_count_q < 4'd15) ? edge_count_q + 4'd1 : edge_count_q;
      end else begin
        edge_count_d = 4'd1;
      end
      gesture_open_d = 1'b1;
      tap_cd_d       = arm_timer(tap_window_q);
      button_chg_d   = 1'b1;
      stroke_d       = 1'b1;
    end

    out_data_d.data_ready = button_chg_d | move_chg_d;
  end

  // Advance gesture state once per processed transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q        <= '0;
      pos_y_q        <= '0;
      prev_x_q       <= '0;
      prev_y_q       <= '0;
      contact_raw_q  <= 1'b0;
      contact_filt_q <= 1'b0;
      stroke_q       <= 1'b0;
      phase_q        <= PhaseNone;
      bounce_cd_q    <= '0;
      tap_cd_q       <= '0;
      gesture_open_q <= 1'b0;
      edge_count_q   <= '0;
      pulses_q       <= '0;
      button_chg_q   <= 1'b0;
      move_chg_q     <= 1'b0;
    end else if (advance) begin
      pos_x_q        <= pos_x_d;
      pos_y_q        <= pos_y_d;
      prev_x_q       <= prev_x_d;
      prev_y_q       <= prev_y_d;
      contact_raw_q  <= contact_raw_d;
      contact_filt_q <= contact_filt_d;
      stroke_q       <= stroke_d;
      phase_q        <= phase_d;
      bounce_cd_q    <= bounce_cd_d;
      tap_cd_q       <= tap_cd_d;
      gesture_open_q <= gesture_open_d;
      edge_count_q   <= edge_count_d;
      pulses_q       <= pulses_d;
      button_chg_q   <= button_chg_d;
      move_chg_q     <= move_chg_d;
    end
  end

`ifndef SYNTHESIS
  // A pending debounce always has a running countdown.
  a_phase_has_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PhaseNone) |-> (bounce_cd_q != '0))
    else $error("debounce phase without countdown");

  // An open gesture has counted at least one transition.
  a_open_has_edges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gesture_open_q |-> (edge_count_q != 4'd0))
    else $error("open gesture with zero edge count");

  // Non-packet results carry zero bytes.
  a_idle_bytes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.packet_valid) |->
      (out_data_o.byte0 == 8'd0 && out_data_o.byte1 == 8'd0 && out_data_o.byte2 == 8'd0))
    else $error("bytes set on a non-packet result");

  // With the result register empty the input side never stalls.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");
`endif

endmodule

[tb/ttdg_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ttdg_tb_pkg
// Scoreboard for the tap and drag gesture engine: tracks gesture state
// independently of the RTL and compares every returned packet against it.
// ----------------------------------------------------------------------------
package ttdg_tb_pkg;
  import ttdg_pkg::*;

  localparam logic [1:0] ReqUnused  = 2'd3;

  class gesture_scoreboard;
    // Register copies
    logic [1:0]  mode_r;
    logic [9:0]  bounce_r, sticky_r, tapwin_r;
    // Gesture state
    logic [9:0]  cur_x, cur_y, last_rd_x, last_rd_y;
    logic        raw_dn, filt_dn, stroke;
    logic [1:0]  phase;
    logic [10:0] bounce_cd, tap_cd;
    logic        gesture;
    logic [3:0]  edges, owed;
    logic        btn_pend, move_pend;

    ttdg_out_t   pending_pkts[$];
    int unsigned fail_cnt;

    function new();
      mode_r    = ModePs2;
      bounce_r  = 10'd5;
      sticky_r  = 10'd80;
      tapwin_r  = 10'd30;
      cur_x     = '0;
      cur_y     = '0;
      last_rd_x = '0;
      last_rd_y = '0;
      raw_dn    = 1'b0;
      filt_dn   = 1'b0;
      stroke    = 1'b0;
      phase     = PhaseNone;
      bounce_cd = '0;
      tap_cd    = '0;
      gesture   = 1'b0;
      edges     = '0;
      owed      = '0;
      btn_pend  = 1'b0;
      move_pend = 1'b0;
      fail_cnt  = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [9:0] val);
      case (idx)
        RegReportMode: mode_r   = val[1:0];
        RegBounce:     bounce_r = val;
        RegSticky:     sticky_r = val;
        RegTapWindow:  tapwin_r = val;
        default: ;
      endcase
    endfunction

    function logic [10:0] load_count(logic [9:0] ticks);
      return {1'b0, ticks} + 11'd1;
    endfunction

    // Count down; fire on the tick at which the count reaches one.
    function bit count_down(inout logic [10:0] cd);
      if (cd == '0) return 1'b0;
      if (cd > 11'd1) cd--;
      if (cd == 11'd1) begin
        cd = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void mark_edge();
      if (gesture) begin
        if (edges != 4'd15) edges++;
      end else begin
        edges   = 4'd1;
        gesture = 1'b1;
      end
      tap_cd   = load_count(tapwin_r);
      btn_pend = 1'b1;
      stroke   = 1'b1;
    endfunction

    function void bounce_done();
      if (phase == PhaseUp || phase == PhaseSticky) begin
        phase   = PhaseNone;
        filt_dn = raw_dn;
        mark_edge();
      end else if (phase == PhaseDown) begin
        phase = PhaseNone;
      end
    endfunction

    function void tap_done();
      logic [4:0] sum;
      if (edges == 4'd2 || edges == 4'd4 || edges == 4'd6) begin
        sum      = {1'b0, owed} + {1'b0, edges};
        owed     = (sum > 5'd15) ? 4'd15 : sum[3:0];
        btn_pend = 1'b1;
      end
      gesture = 1'b0;
    endfunction

    function void take_pen(logic [9:0] x, logic [9:0] y, logic d);
      if (x != cur_x || y != cur_y) begin
        cur_x     = x;
        cur_y     = y;
        move_pend = 1'b1;
      end
      if (d == raw_dn) return;
      raw_dn = d;
      if (phase != PhaseNone) begin
        phase     = PhaseNone;
        bounce_cd = '0;
      end
      if (d) begin
        if (filt_dn) begin
          stroke = 1'b1;
        end else begin
          phase     = PhaseDown;
          bounce_cd = load_count(bounce_r);
          filt_dn   = 1'b1;
          mark_edge();
        end
      end else if (gesture) begin
        filt_dn = 1'b0;
        mark_edge();
      end else if (edges == 4'd3) begin
        phase     = PhaseSticky;
        bounce_cd = load_count(sticky_r);
      end else begin
        phase     = PhaseUp;
        bounce_cd = load_count(bounce_r);
      end
    endfunction

    function logic pop_button();
      logic b;
      if (owed != '0) begin
        owed--;
        b = owed[0];
      end else begin
        b = !gesture && (edges == 4'd3);
      end
      btn_pend = (owed != '0);
      return b;
    endfunction

    function void read_packet(output ttdg_out_t p);
      logic        d, f, s, b;
      logic [9:0]  x, y;
      logic [10:0] dx, dy;
      d = raw_dn;
      f = filt_dn;
      s = stroke;
      x = cur_x;
      y = cur_y;
      p = '0;
      if (mode_r == ModeUnused) return;
      move_pend = 1'b0;
      stroke    = 1'b0;
      case (mode_r)
        ModeRaw: begin
          p.byte0 = {d, 1'b0, x[9:8], f, 1'b0, y[9:8]};
          p.byte1 = x[7:0];
          p.byte2 = y[7:0];
        end
        ModeDebug: begin
          p.byte0 = {d, f, s, 3'b000, phase};
          p.byte1 = {gesture, 3'b000, edges};
          b       = pop_button();
          p.byte2 = {owed, 3'b000, b};
        end
        default: begin
          b  = pop_button();
          dx = '0;
          dy = '0;
          if (!s && phase == PhaseNone) begin
            dx = {1'b0, x} - {1'b0, last_rd_x};
            dy = {1'b0, last_rd_y} - {1'b0, y};
          end
          last_rd_x = x;
          last_rd_y = y;
          p.byte0   = {2'b00, dy[10], dx[10], !b, 3'b000};
          p.byte1   = dx[7:0];
          p.byte2   = dy[7:0];
        end
      endcase
      p.packet_valid = 1'b1;
    endfunction

    function ttdg_out_t gesture_step(ttdg_in_t it);
      ttdg_out_t p;
      bit        bf, tf;
      p = '0;
      case (it.req_type)
        ReqPen: take_pen(it.x_coord, it.y_coord, it.pen_down);
        ReqTick: begin
          // Bounce timer is serviced first; a re-armed tap timer drops its expiry.
          bf = count_down(bounce_cd);
          tf = count_down(tap_cd);
          if (bf) bounce_done();
          if (tf && tap_cd == '0) tap_done();
        end
        ReqRead: read_packet(p);
        default: ;
      endcase
      p.data_ready = btn_pend | move_pend;
      return p;
    endfunction

    function void note_sample(ttdg_in_t it);
      pending_pkts.push_back(gesture_step(it));
    endfunction

    function int unsigned outstanding();
      return pending_pkts.size();
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      if (fail_cnt < 100)
        $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
      fail_cnt++;
    endtask

    task check_packet(ttdg_out_t got);
      ttdg_out_t want;
      if (pending_pkts.size() == 0) begin
        report("unexpected result", 8'h00, 8'h00);
        return;
      end
      want = pending_pkts.pop_front();
      if (got.packet_valid !== want.packet_valid)
        report("packet_valid", {7'b0, got.packet_valid}, {7'b0, want.packet_valid});
      if (got.byte0 !== want.byte0) report("byte0", got.byte0, want.byte0);
      if (got.byte1 !== want.byte1) report("byte1", got.byte1, want.byte1);
      if (got.byte2 !== want.byte2) report("byte2", got.byte2, want.byte2);
      if (got.data_ready !== want.data_ready)
        report("data_ready", {7'b0, got.data_ready}, {7'b0, want.data_ready});
    endtask
  endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives pen samples, ticks and packet reads into the gesture engine under
// several register settings, with random idle cycles on both channels, and
// checks every returned packet against the scoreboard's own gesture tracking.
// ----------------------------------------------------------------------------
module tb_top;
  import ttdg_pkg::*;
  import ttdg_tb_pkg::*;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  ttdg_in_t   in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  ttdg_out_t  out_data_o;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [9:0] cfg_data_i  = '0;

  // Stimulus bookkeeping: idle enable, item budget of the current phase,
  // the pen as last sent, and the timer settings in force.
  bit          idle_on = 1'b1;
  int unsigned phase_left;
  logic        pen_is_down = 1'b0;
  logic [9:0]  pen_x = '0;
  logic [9:0]  pen_y = '0;
  logic [9:0]  cur_bounce = 10'd5;
  logic [9:0]  cur_sticky = 10'd80;
  logic [9:0]  cur_tap    = 10'd30;

  gesture_scoreboard sb = new();

  touchpad_tap_drag_gesture_engine i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Stall the result channel at random, about 23 times in 100, unless idling is off.
  always @(posedge clk_i) begin
    out_ready_i <= !idle_on || ($urandom_range(99) >= 23);
  end

  // Monitor both channels. Values read here are the ones from before the
  // edge, so a transaction is seen exactly when the DUT takes it.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_sample(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_packet(out_data_o);
  end

  // Hard stop: far above the slowest legal run of a few thousand items.
  initial begin
    #400_000;
    $display("TB_ERROR");
    $finish;
  end

  // Present one input transaction and hold it until accepted. An optional
  // random gap comes first; valid drops only in a step where it is not raised.
  task automatic send_item(input logic [1:0] kind, input logic [9:0] x,
                           input logic [9:0] y, input logic d);
    ttdg_in_t it;
    it.req_type = kind;
    it.x_coord  = x;
    it.y_coord  = y;
    it.pen_down = d;
    if (idle_on && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 23);
    end
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (phase_left > 0) phase_left--;
  endtask

  task automatic pen(input logic [9:0] x, input logic [9:0] y, input logic d);
    pen_x       = x;
    pen_y       = y;
    pen_is_down = d;
    send_item(ReqPen, x, y, d);
  endtask

  // Reads and ticks carry random position fields; the block must ignore them.
  task automatic read_pkt();
    send_item(ReqRead, 10'($urandom), 10'($urandom), 1'($urandom));
  endtask

  task automatic maybe_read();
    if ($urandom_range(99) < 30) read_pkt();
  endtask

  task automatic tick_run(input int unsigned n);
    repeat (n) begin
      if (phase_left == 0) break;
      send_item(ReqTick, 10'($urandom), 10'($urandom), 1'($urandom));
    end
  endtask

  // Wait until every accepted transaction has returned and let the pipeline empty.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all four registers back to back while the block is idle.
  task automatic apply_settings(input logic [1:0] mode, input logic [9:0] bounce,
                                input logic [9:0] sticky, input logic [9:0] tap);
    logic [9:0] vals[4];
    drain();
    vals[RegReportMode] = {8'b0, mode};
    vals[RegBounce]     = bounce;
    vals[RegSticky]     = sticky;
    vals[RegTapWindow]  = tap;
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= 2'(i);
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      sb.set_reg(2'(i), vals[i]);
    end
    cfg_we_i   <= 1'b0;
    cur_bounce = bounce;
    cur_sticky = sticky;
    cur_tap    = tap;
  endtask

  // Tick run lengths range up to just past each timer so expiries land on both sides.
  function automatic int unsigned pick_len();
    case ($urandom_range(3))
      0:       return $urandom_range(3);
      1:       return $urandom_range(cur_bounce + 2);
      2:       return $urandom_range(cur_sticky + 2);
      default: return $urandom_range(cur_tap + 2);
    endcase
  endfunction

  // Toggle contact n times; rapid gestures skip the ticks between edges
  // so the edge count can climb to saturation.
  task automatic tap_gesture(input int unsigned n, input bit rapid);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) pen_x = pen_x + 10'($urandom_range(6)) - 10'd3;
      pen(pen_x, pen_y, !pen_is_down);
      maybe_read();
      if (!rapid) tick_run(pick_len());
    end
    tick_run(pick_len() + pick_len());
    maybe_read();
  endtask

  // Move the pen with small steps and the odd jump, reading often.
  task automatic move_burst();
    int unsigned k;
    k = $urandom_range(6, 1);
    repeat (k) begin
      if ($urandom_range(9) == 0) begin
        pen_x = 10'($urandom);
        pen_y = 10'($urandom);
      end else begin
        pen_x = pen_x + 10'($urandom_range(40)) - 10'd20;
        pen_y = pen_y + 10'($urandom_range(40)) - 10'd20;
      end
      pen(pen_x, pen_y, pen_is_down);
      if ($urandom_range(1) == 1) read_pkt();
    end
  endtask

  // Mostly well-formed gestures and moves, plus noise and unused kinds.
  task automatic run_phase(input int unsigned budget);
    int unsigned r;
    logic [1:0]  kind;
    phase_left = budget;
    while (phase_left > 0) begin
      r = $urandom_range(99);
      if (r < 55) begin
        tap_gesture($urandom_range(7, 1), 1'b0);
      end else if (r < 63) begin
        tap_gesture($urandom_range(18, 14), 1'b1);
      end else if (r < 82) begin
        move_burst();
      end else if (r < 96) begin
        kind = 2'($urandom_range(2));
        if (kind == ReqPen) pen(10'($urandom), 10'($urandom), 1'($urandom));
        else send_item(kind, 10'($urandom), 10'($urandom), 1'($urandom));
      end else begin
        send_item(ReqUnused, 10'($urandom), 10'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    // Hold reset once at the start, then release it.
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset defaults, relative mode and coordinate extremes; with the
    // pen-down debounce still pending, the reads report zero deltas.
    phase_left = '1;
    read_pkt();
    pen(10'd1023, 10'd1023, 1'b1);
    read_pkt();
    pen(10'd0, 10'd0, 1'b1);
    read_pkt();
    pen(10'd1023, 10'd0, 1'b1);
    read_pkt();

    // Raw mode, then a pen-up inside the open gesture and a window close
    // after two contact transitions.
    apply_settings(ModeRaw, 10'd1, 10'd3, 10'd2);
    phase_left = '1;
    read_pkt();
    pen(10'd1023, 10'd1023, 1'b0);
    read_pkt();
    tick_run(3);

    // Debug mode: drain the owed pulses, then a triple transition and the
    // sticky drag hold.
    apply_settings(ModeDebug, 10'd1, 10'd3, 10'd2);
    phase_left = '1;
    repeat (3) read_pkt();
    pen(10'd5, 10'd5, 1'b1);
    pen(10'd5, 10'd5, 1'b0);
    pen(10'd5, 10'd5, 1'b1);
    tick_run(4);
    pen(10'd5, 10'd5, 1'b0);
    read_pkt();
    tick_run(5);
    read_pkt();
    send_item(ReqUnused, 10'h3FF, 10'h3FF, 1'b1);

    // Unused report mode answers with no packet.
    apply_settings(ModeUnused, 10'd1, 10'd3, 10'd2);
    phase_left = '1;
    read_pkt();

    // Random phases over several settings; zero timers make bounce and
    // tap expire on the same tick.
    apply_settings(ModePs2, 10'd5, 10'd80, 10'd30);
    run_phase(120);
    apply_settings(ModeDebug, 10'd0, 10'd0, 10'd0);
    run_phase(70);
    apply_settings(ModeRaw, 10'd3, 10'd12, 10'd8);
    run_phase(70);

    // Long stretch with no idling on either side.
    idle_on = 1'b0;
    apply_settings(ModePs2, 10'd2, 10'd6, 10'd10);
    run_phase(150);
    idle_on = 1'b1;

    apply_settings(ModeDebug, 10'd1, 10'd20, 10'd5);
    run_phase(60);

    // Settle the pen up so the next down edge arms both timers fresh.
    phase_left = '1;
    if (pen_is_down) pen(pen_x, pen_y, 1'b0);
    tick_run(cur_bounce + cur_sticky + cur_tap + 3);

    // Largest timers: run both countdowns to their last tick and past it.
    apply_settings(ModeDebug, 10'd1023, 10'd1023, 10'd1023);
    phase_left = '1;
    pen(pen_x, pen_y, 1'b1);
    tick_run(1023);
    read_pkt();
    tick_run(1);
    read_pkt();
    run_phase(20);

    apply_settings(ModeUnused, 10'd4, 10'd9, 10'd7);
    run_phase(20);

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.fail_cnt == 0 && sb.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[touchpad_tap_drag_gesture_engine.f]
rtl/core/ttdg_pkg.sv
rtl/core/touchpad_tap_drag_gesture_engine.sv
tb/ttdg_tb_pkg.sv
tb/tb_top.sv
